// File: rtl/lcri_pkg.sv
// shared constants and types for the lan card register interface
package lcri_pkg;

    localparam int REGS_PER_BANK   = 17;
    localparam int DEF_RX_DEPTH    = 2048;
    localparam int DEF_BANK_COUNT  = 4;
    localparam int FIFO_LANES      = 4;

    // receive fifo status towards the request decoder
    typedef struct packed {
        logic       empty;
        logic       multi;
        logic [1:0] lane0;
        logic [1:0] lane1;
        logic       next_full;
        logic       ovf;
    } t_fifo_stat;

endpackage

// File: rtl/lcri_bank.sv
// banked register file: one write port, two registered read ports, 0xFF until written
module lcri_bank #(
    parameter int BANK_COUNT = lcri_pkg::DEF_BANK_COUNT,
    parameter int AW         = $clog2(BANK_COUNT * lcri_pkg::REGS_PER_BANK)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [7:0]         i_wdata,
    input  logic               i_re,
    input  logic [1:0][AW-1:0] i_raddr,
    output logic [1:0][7:0]    o_q
);
    localparam int DEPTH = BANK_COUNT * lcri_pkg::REGS_PER_BANK;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [1:0][7:0]  r_q;
    logic [1:0]       r_q_vld;

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q[0] <= mem[i_raddr[0]];
            r_q[1] <= mem[i_raddr[1]];
        end
    end

    // written flags, reset gives 0xFF everywhere
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= '0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_q_vld[0] <= r_vld[i_raddr[0]];
                r_q_vld[1] <= r_vld[i_raddr[1]];
            end
        end
    end

    assign o_q[0] = r_q_vld[0] ? r_q[0] : 8'hFF;
    assign o_q[1] = r_q_vld[1] ? r_q[1] : 8'hFF;

endmodule

// File: rtl/lcri_rxfifo.sv
// receive byte fifo: four interleaved lanes, up to four pushes or two pops per request
module lcri_rxfifo #(
    parameter int RX_DEPTH = lcri_pkg::DEF_RX_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [2:0]            i_push_n,
    input  logic [3:0][7:0]       i_push_byte,
    input  logic [1:0]            i_pop_n,
    output lcri_pkg::t_fifo_stat  o_stat,
    output logic [3:0][7:0]       o_q
);
    localparam int AW   = $clog2(RX_DEPTH);
    localparam int CW   = $clog2(RX_DEPTH + 1);
    localparam int ROWS = RX_DEPTH / lcri_pkg::FIFO_LANES;
    localparam int RW   = $clog2(ROWS);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] space;
    logic [2:0]    npush;
    logic [AW-1:0] tail, a0, a1;
    logic [3:0]    w_we;
    logic [RW-1:0] w_row [4];
    logic [7:0]    w_wd  [4];
    logic [RW-1:0] rd_row [4];

    // wrap an address sum back into the store
    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] d;
        d = s - (AW+1)'(RX_DEPTH);
        return (s >= (AW+1)'(RX_DEPTH)) ? d[AW-1:0] : s[AW-1:0];
    endfunction

    // push and pop accounting
    always_comb begin
        logic [1:0]    k;
        logic [AW-1:0] ak;
        space   = CW'(RX_DEPTH) - r_count;
        npush   = (CW'(i_push_n) > space) ? space[2:0] : i_push_n;
        tail    = wrap({1'b0, r_head} + (AW+1)'(r_count));
        a0      = r_head;
        a1      = wrap({1'b0, r_head} + (AW+1)'(1));
        n_head  = wrap({1'b0, r_head} + (AW+1)'(i_pop_n));
        n_count = r_count + CW'(npush) - CW'(i_pop_n);
        for (int j = 0; j < 4; j++) begin
            k         = 2'(j) - tail[1:0];
            ak        = wrap({1'b0, tail} + (AW+1)'(k));
            w_we[j]   = i_step && ({1'b0, k} < npush);
            w_row[j]  = ak[AW-1:2];
            w_wd[j]   = i_push_byte[k];
            rd_row[j] = (2'(j) == a0[1:0]) ? a0[AW-1:2] : a1[AW-1:2];
        end
    end

    // lane stores
    for (genvar j = 0; j < 4; j++) begin : g_lane
        logic [7:0] mem [ROWS];
        logic [7:0] r_q;
        always_ff @(posedge i_clk) begin
            if (w_we[j]) begin
                mem[w_row[j]] <= w_wd[j];
            end
            if (i_step) begin
                r_q <= mem[rd_row[j]];
            end
        end
        assign o_q[j] = r_q;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.multi     = (r_count >= CW'(2));
    assign o_stat.lane0     = a0[1:0];
    assign o_stat.lane1     = a1[1:0];
    assign o_stat.next_full = (n_count != '0);
    assign o_stat.ovf       = (CW'(i_push_n) > space);

endmodule

// File: rtl/lan_card_register_interface.sv
// top level: request decode, state update and result pipeline
// results pass two stages, stage one and the output register, after a request is accepted
// throughput: one request per cycle absent output stalls, set by register file and fifo ports
// a packet start writes up to four fifo lanes at once, a word read pops up to two lanes
// reset (synchronous, active low) clears pointers, counters, flags and valid bits;
// the register file reads 0xFF until written, the fifo store needs no clearing
module lan_card_register_interface #(
    parameter int RX_DEPTH   = lcri_pkg::DEF_RX_DEPTH,
    parameter int BANK_COUNT = lcri_pkg::DEF_BANK_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_wdata,  // mac_address
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // req_type[2:0], port_offset[7:3], write_data[15:8], rx_length[31:16], rx_byte[39:32]
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // read_data[15:0], irq_request[16], irq_line[20:17], tx_valid[21], tx_byte[29:22],
    // tx_length[41:30], rx_overflow[42], zero fill
    output logic [47:0] o_m_tdata,
    output logic        o_m_tlast     // tx_end
);
    localparam int BAW = $clog2(BANK_COUNT * lcri_pkg::REGS_PER_BANK);

    typedef enum logic [2:0] {
        REQ_BWR   = 3'd0,
        REQ_BRD   = 3'd1,
        REQ_WRD   = 3'd2,
        REQ_PKT   = 3'd3,
        REQ_PBYTE = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        SRC_CONST = 3'd0,
        SRC_MEM   = 3'd1,
        SRC_STAT5 = 3'd2,
        SRC_POP0  = 3'd3,
        SRC_POP1  = 3'd4
    } t_src;

    typedef struct packed {
        t_src       kind;
        logic [7:0] val;
    } t_bsrc;

    typedef struct packed {
        logic        irq;
        logic [3:0]  line;
        logic        txv;
        logic [7:0]  txb;
        logic        txe;
        logic [11:0] txl;
        logic        ovf;
    } t_side;

    localparam logic [4:0]  OFF_RXSTAT  = 5'd1;
    localparam logic [4:0]  OFF_TXIE    = 5'd2;
    localparam logic [4:0]  OFF_RXIE    = 5'd3;
    localparam logic [4:0]  OFF_STAT5   = 5'd5;
    localparam logic [4:0]  OFF_CFG0    = 5'd6;
    localparam logic [4:0]  OFF_CFG1    = 5'd7;
    localparam logic [4:0]  OFF_BUF0    = 5'd8;
    localparam logic [4:0]  OFF_BUF1    = 5'd9;
    localparam logic [4:0]  OFF_TXGO    = 5'd10;
    localparam logic [4:0]  OFF_PRE_ROM = 5'd15;
    localparam logic [4:0]  OFF_ROM     = 5'd16;
    localparam logic [1:0]  BANK_BUF    = 2'd2;
    localparam logic [7:0]  MASK_TXIE   = 8'h82;
    localparam logic [7:0]  MASK_RXIE   = 8'h81;
    localparam logic [7:0]  MASK_TXGO   = 8'h81;
    localparam logic [7:0]  BIT_EMPTY   = 8'h40;
    localparam logic [7:0]  HDR_BYTE    = 8'h20;
    localparam logic [7:0]  ROM_ID      = 8'hA2;
    localparam logic [23:0] ROM_TAG     = 24'h4C414E;
    localparam logic [11:0] TX_MAX      = 12'd4095;

    // id rom bit stream
    function automatic logic rom_bit(input logic [7:0] p, input logic [47:0] mac);
        logic [7:0] d_mac, d_id, d_tag;
        d_mac = p - 8'd20;
        d_id  = p - 8'd68;
        d_tag = p - 8'd232;
        if (p < 8'd4)        return 1'b0;
        else if (p < 8'd20)  return 1'b1;
        else if (p < 8'd68)  return mac[d_mac[5:0]];
        else if (p < 8'd76)  return ROM_ID[d_id[2:0]];
        else if (p < 8'd232) return 1'b1;
        else if (p < 8'd252) return ROM_TAG[d_tag[4:0]];
        else                 return 1'b0;
    endfunction

    function automatic logic [3:0] irq_num(input logic [3:0] sel);
        case (sel)
            4'd1:    return 4'd4;
            4'd2:    return 4'd5;
            4'd4:    return 4'd10;
            4'd8:    return 4'd14;
            default: return 4'd0;
        endcase
    endfunction

    // where one read byte comes from
    function automatic t_bsrc src_of(input logic [5:0] o, input logic is_buf,
                                     input logic empty, input logic [7:0] cfg0,
                                     input logic [7:0] cfg1, input logic [7:0] rom);
        t_bsrc s;
        s.kind = SRC_CONST;
        s.val  = 8'hFF;
        if (o > {1'b0, OFF_ROM}) begin
            s.val = 8'hFF;
        end else if (is_buf) begin
            s.kind = empty ? SRC_CONST : SRC_POP0;
            s.val  = 8'h00;
        end else begin
            case (o[4:0])
                OFF_RXSTAT: s.val = empty ? 8'h00 : 8'hFF;
                OFF_STAT5: begin
                    s.kind = SRC_STAT5;
                    s.val  = empty ? BIT_EMPTY : 8'h00;
                end
                OFF_CFG0: s.val = cfg0;
                OFF_CFG1: s.val = cfg1;
                OFF_ROM:  s.val = rom;
                default:  s.kind = SRC_MEM;
            endcase
        end
        return s;
    endfunction

    function automatic logic [7:0] byte_val(input t_bsrc s, input logic [7:0] memq,
                                            input logic [7:0] pop0, input logic [7:0] pop1);
        case (s.kind)
            SRC_MEM:   return memq;
            SRC_STAT5: return (memq & ~BIT_EMPTY) | s.val;
            SRC_POP0:  return pop0;
            SRC_POP1:  return pop1;
            default:   return s.val;
        endcase
    endfunction

    // control state
    logic [47:0] r_mac;
    logic [11:0] r_tx_cnt, n_tx_cnt;
    logic [7:0]  r_rom_ptr, n_rom_ptr;
    logic        r_rx_ie, n_rx_ie;
    logic        r_tx_ie, n_tx_ie;
    logic [7:0]  r_cfg0, n_cfg0;
    logic [7:0]  r_cfg1, n_cfg1;
    logic [3:0]  r_irq_sel, n_irq_sel;

    // pipeline
    logic        r_s1_valid;
    t_bsrc       r_lo, r_hi;
    t_side       r_side;
    logic [1:0]  r_lane0, r_lane1;
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic        r_out_last;

    logic        accept, adv1;
    t_req        req;
    logic [4:0]  off;
    logic [5:0]  off_hi;
    logic [7:0]  wd;
    logic [2:0]  bank_raw;
    logic [1:0]  bank;
    logic        in_bank_buf;
    logic [7:0]  rom_byte;
    t_bsrc       lo, hi;
    t_side       side;
    logic        bank_we;
    logic [BAW-1:0]       bank_base;
    logic [1:0][BAW-1:0]  bank_raddr;
    logic [1:0][7:0]      bank_q;
    logic [2:0]           push_n;
    logic [3:0][7:0]      push_byte;
    logic [1:0]           pop_n;
    lcri_pkg::t_fifo_stat fst;
    logic [3:0][7:0]      lane_q;
    logic [7:0]           res_lo, res_hi;

    assign adv1       = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || adv1;
    assign accept     = i_s_tvalid && o_s_tready;

    // field split and bank selection
    always_comb begin
        req         = t_req'(i_s_tdata[2:0]);
        off         = i_s_tdata[7:3];
        wd          = i_s_tdata[15:8];
        off_hi      = {1'b0, off} + 6'd1;
        bank_raw    = {1'b0, r_cfg1[3:2]};
        bank        = (bank_raw >= 3'(BANK_COUNT)) ? 2'(bank_raw - 3'(BANK_COUNT))
                                                  : bank_raw[1:0];
        in_bank_buf = (bank == BANK_BUF);
        rom_byte    = {r_irq_sel, 3'b000, rom_bit(r_rom_ptr, r_mac)};
        bank_base   = BAW'({bank, 4'b0000}) + BAW'(bank);
        bank_raddr[0] = bank_base + ((off <= OFF_ROM) ? BAW'(off) : BAW'(0));
        bank_raddr[1] = bank_base + ((off_hi <= {1'b0, OFF_ROM}) ? BAW'(off_hi) : BAW'(0));
    end

    // request decode and state update
    always_comb begin
        lo        = '{kind: SRC_CONST, val: 8'h00};
        hi        = '{kind: SRC_CONST, val: 8'h00};
        side      = '0;
        bank_we   = 1'b0;
        push_n    = 3'd0;
        push_byte = '0;
        pop_n     = 2'd0;
        n_tx_cnt  = r_tx_cnt;
        n_rom_ptr = r_rom_ptr;
        n_rx_ie   = r_rx_ie;
        n_tx_ie   = r_tx_ie;
        n_cfg0    = r_cfg0;
        n_cfg1    = r_cfg1;
        n_irq_sel = r_irq_sel;
        if (accept) begin
            unique case (req)
                REQ_BWR: begin
                    if (off <= OFF_ROM) begin
                        bank_we = 1'b1;
                        unique case (off)
                            OFF_TXIE: n_tx_ie = ((wd & MASK_TXIE) == MASK_TXIE);
                            OFF_RXIE: n_rx_ie = ((wd & MASK_RXIE) == MASK_RXIE);
                            OFF_CFG0: n_cfg0  = wd;
                            OFF_CFG1: n_cfg1  = wd;
                            OFF_ROM: begin
                                if (wd[3:0] == 4'd0) begin
                                    n_rom_ptr = 8'd0;
                                end
                                if ($onehot(wd[7:4])) begin
                                    n_irq_sel = wd[7:4];
                                end
                            end
                            default: ;
                        endcase
                        if (in_bank_buf && (off == OFF_BUF0 || off == OFF_BUF1)) begin
                            side.txv = 1'b1;
                            side.txb = wd;
                            if (r_tx_cnt < TX_MAX) begin
                                n_tx_cnt = r_tx_cnt + 12'd1;
                            end
                        end else if (in_bank_buf && off == OFF_TXGO
                                     && (wd & MASK_TXGO) == MASK_TXGO) begin
                            side.txe = 1'b1;
                            side.txl = r_tx_cnt;
                            n_tx_cnt = 12'd0;
                        end
                    end
                end
                REQ_BRD: begin
                    lo = src_of({1'b0, off},
                                in_bank_buf && (off == OFF_BUF0 || off == OFF_BUF1),
                                fst.empty, r_cfg0, r_cfg1, rom_byte);
                    pop_n = (lo.kind == SRC_POP0) ? 2'd1 : 2'd0;
                    if (off == OFF_ROM) begin
                        n_rom_ptr = r_rom_ptr + 8'd1;
                    end
                end
                REQ_WRD: begin
                    if (in_bank_buf && off == OFF_BUF0) begin
                        lo.kind = fst.empty ? SRC_CONST : SRC_POP0;
                        hi.kind = fst.multi ? SRC_POP1 : SRC_CONST;
                        pop_n   = fst.empty ? 2'd0 : (fst.multi ? 2'd2 : 2'd1);
                    end else begin
                        lo = src_of({1'b0, off},
                                    in_bank_buf && off == OFF_BUF1,
                                    fst.empty, r_cfg0, r_cfg1, rom_byte);
                        hi = src_of(off_hi,
                                    in_bank_buf && off_hi == {1'b0, OFF_BUF0},
                                    fst.empty, r_cfg0, r_cfg1, rom_byte);
                        pop_n = (lo.kind == SRC_POP0 || hi.kind == SRC_POP0) ? 2'd1 : 2'd0;
                        if (off == OFF_ROM || off == OFF_PRE_ROM) begin
                            n_rom_ptr = r_rom_ptr + 8'd1;
                        end
                    end
                end
                REQ_PKT: begin
                    push_n    = 3'd4;
                    push_byte = {i_s_tdata[31:24], i_s_tdata[23:16], 8'h00, HDR_BYTE};
                    side.ovf  = fst.ovf;
                end
                REQ_PBYTE: begin
                    push_n       = 3'd1;
                    push_byte[0] = i_s_tdata[39:32];
                    side.ovf     = fst.ovf;
                end
                default: ;
            endcase
        end
        side.irq  = n_rx_ie && fst.next_full;
        side.line = irq_num(n_irq_sel);
    end

    lcri_bank #(
        .BANK_COUNT (BANK_COUNT),
        .AW         (BAW)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (bank_we),
        .i_waddr (bank_raddr[0]),
        .i_wdata (wd),
        .i_re    (accept),
        .i_raddr (bank_raddr),
        .o_q     (bank_q)
    );

    lcri_rxfifo #(
        .RX_DEPTH (RX_DEPTH)
    ) u_rxfifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept),
        .i_push_n    (push_n),
        .i_push_byte (push_byte),
        .i_pop_n     (pop_n),
        .o_stat      (fst),
        .o_q         (lane_q)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac     <= '0;
            r_tx_cnt  <= '0;
            r_rom_ptr <= '0;
            r_rx_ie   <= 1'b0;
            r_tx_ie   <= 1'b0;
            r_cfg0    <= '0;
            r_cfg1    <= '0;
            r_irq_sel <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mac <= i_cfg_wdata;
            end
            r_tx_cnt  <= n_tx_cnt;
            r_rom_ptr <= n_rom_ptr;
            r_rx_ie   <= n_rx_ie;
            r_tx_ie   <= n_tx_ie;
            r_cfg0    <= n_cfg0;
            r_cfg1    <= n_cfg1;
            r_irq_sel <= n_irq_sel;
        end
    end

    // stage one: waits for memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lo    <= lo;
            r_hi    <= hi;
            r_side  <= side;
            r_lane0 <= fst.lane0;
            r_lane1 <= fst.lane1;
        end
    end

    // read data assembly
    assign res_lo = byte_val(r_lo, bank_q[0], lane_q[r_lane0], lane_q[r_lane1]);
    assign res_hi = byte_val(r_hi, bank_q[1], lane_q[r_lane0], lane_q[r_lane1]);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv1) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_s1_valid) begin
            r_out_data <= {5'b00000, r_side.ovf, r_side.txl, r_side.txb, r_side.txv,
                           r_side.line, r_side.irq, res_hi, res_lo};
            r_out_last <= r_side.txe;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push_n != 3'd0 && pop_n != 2'd0))
        else $error("fifo push and pop in one request");

    a_end_not_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> !o_m_tdata[21])
        else $error("frame end carries a transmit byte");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv1) |=> r_s1_valid)
        else $error("stalled request lost from stage one");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_tready) |-> !accept)
        else $error("request accepted while pipeline full");
`endif

endmodule

// File: test/tb_lan_card_register_interface.sv
// self-checking testbench for the lan card register interface
`timescale 1ns / 100ps

module tb_lan_card_register_interface;

    localparam int RX_DEPTH    = 2048;
    localparam int BANK_COUNT  = 4;
    localparam int NUM_REGS    = 17;
    localparam int TX_MAX      = 4095;
    localparam int CYCLE_LIMIT = 400000;

    // request kinds
    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_WORD  = 3'd2;
    localparam logic [2:0] REQ_PKT   = 3'd3;
    localparam logic [2:0] REQ_BYTE  = 3'd4;

    // register offsets
    localparam logic [4:0] OFS_STATUS = 5'd1;
    localparam logic [4:0] OFS_TXIE   = 5'd2;
    localparam logic [4:0] OFS_RXIE   = 5'd3;
    localparam logic [4:0] OFS_STAT5  = 5'd5;
    localparam logic [4:0] OFS_CFG0   = 5'd6;
    localparam logic [4:0] OFS_CFG1   = 5'd7;
    localparam logic [4:0] OFS_BUF0   = 5'd8;
    localparam logic [4:0] OFS_BUF1   = 5'd9;
    localparam logic [4:0] OFS_TXGO   = 5'd10;
    localparam logic [4:0] OFS_ROM    = 5'd16;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  ofs;
        logic [7:0]  wdata;
        logic [15:0] len;
        logic [7:0]  rbyte;
    } t_req;

    typedef struct packed {
        logic [15:0] rdata;
        logic        irq;
        logic [3:0]  line;
        logic        txv;
        logic [7:0]  txb;
        logic        txe;
        logic [11:0] txl;
        logic        ovf;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [47:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic        o_m_tlast;

    lan_card_register_interface dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // card state as predicted
    logic [7:0]  bank_regs [BANK_COUNT*NUM_REGS];
    logic [7:0]  rx_mem [RX_DEPTH];
    int          rx_rd, rx_fill, tx_cnt;
    logic [7:0]  rom_ptr;
    logic        rx_ie, tx_ie;
    logic [7:0]  cfg0, cfg1;
    logic [3:0]  irq_sel;
    logic [47:0] station_mac;

    t_resp       pending_resp [$];
    int          errors = 0;
    int          cycles = 0;
    int          resp_seen = 0;
    int          ovf_seen = 0, tx_end_seen = 0;

    function automatic int bank_now();
        return ((cfg1 >> 2) & 3) % BANK_COUNT;
    endfunction

    function automatic bit rx_push(logic [7:0] b);
        int slot;
        if (rx_fill >= RX_DEPTH) return 0;
        slot = (rx_rd + rx_fill) % RX_DEPTH;
        rx_mem[slot] = b;
        rx_fill++;
        return 1;
    endfunction

    function automatic logic [7:0] rx_pop();
        logic [7:0] v;
        if (rx_fill == 0) return 8'h00;
        v = rx_mem[rx_rd];
        rx_rd = (rx_rd + 1) % RX_DEPTH;
        rx_fill--;
        return v;
    endfunction

    function automatic logic id_rom_bit(int p);
        logic [7:0]  sig_a2 = 8'hA2;
        logic [23:0] sig_lan = 24'h4C414E;
        if (p < 4) return 1'b0;
        if (p < 20) return 1'b1;
        if (p < 68) return station_mac[p-20];
        if (p < 76) return sig_a2[p-68];
        if (p < 232) return 1'b1;
        if (p < 252) return sig_lan[p-232];
        return 1'b0;
    endfunction

    function automatic logic [7:0] host_read(int ofs);
        int         b;
        logic [7:0] v;
        b = bank_now();
        if (ofs > OFS_ROM) return 8'hFF;
        v = bank_regs[b*NUM_REGS + ofs];
        case (ofs)
            OFS_STATUS: v = (rx_fill == 0) ? 8'h00 : 8'hFF;
            OFS_STAT5:  v = (rx_fill == 0) ? (v | 8'h40) : (v & ~8'h40);
            OFS_CFG0:   v = cfg0;
            OFS_CFG1:   v = cfg1;
            OFS_ROM: begin
                v = {irq_sel, 3'b000, id_rom_bit(rom_ptr)};
                rom_ptr = rom_ptr + 8'd1;
            end
            default: ;
        endcase
        if (b == 2 && (ofs == OFS_BUF0 || ofs == OFS_BUF1)) v = rx_pop();
        return v;
    endfunction

    // advance the predicted card by one request, return its response
    function automatic t_resp card_step(t_req r);
        t_resp      o;
        logic [3:0] hi;
        int         avail;
        o = '0;
        case (r.kind)
            REQ_WRITE: if (r.ofs <= OFS_ROM) begin
                bank_regs[bank_now()*NUM_REGS + r.ofs] = r.wdata;
                case (r.ofs)
                    OFS_TXIE: tx_ie = ((r.wdata & 8'h82) == 8'h82);
                    OFS_RXIE: rx_ie = ((r.wdata & 8'h81) == 8'h81);
                    OFS_CFG0: cfg0 = r.wdata;
                    OFS_CFG1: cfg1 = r.wdata;
                    OFS_ROM: begin
                        hi = r.wdata[7:4];
                        if (r.wdata[3:0] == 4'd0) rom_ptr = 8'd0;
                        if (hi == 1 || hi == 2 || hi == 4 || hi == 8) irq_sel = hi;
                    end
                    default: ;
                endcase
                if (bank_now() == 2) begin
                    if (r.ofs == OFS_BUF0 || r.ofs == OFS_BUF1) begin
                        o.txv = 1'b1;
                        o.txb = r.wdata;
                        if (tx_cnt < TX_MAX) tx_cnt++;
                    end else if (r.ofs == OFS_TXGO && (r.wdata & 8'h81) == 8'h81) begin
                        o.txe = 1'b1;
                        o.txl = tx_cnt[11:0];
                        tx_cnt = 0;
                    end
                end
            end
            REQ_READ: o.rdata = {8'h00, host_read(r.ofs)};
            REQ_WORD: begin
                if (bank_now() == 2 && r.ofs == OFS_BUF0) begin
                    avail = rx_fill;
                    o.rdata[7:0] = rx_pop();
                    o.rdata[15:8] = (avail >= 2) ? rx_pop() : 8'h00;
                end else begin
                    o.rdata[7:0] = host_read(r.ofs);
                    o.rdata[15:8] = host_read(r.ofs + 1);
                end
            end
            REQ_PKT: begin
                if (!rx_push(8'h20)) o.ovf = 1'b1;
                if (!rx_push(8'h00)) o.ovf = 1'b1;
                if (!rx_push(r.len[7:0])) o.ovf = 1'b1;
                if (!rx_push(r.len[15:8])) o.ovf = 1'b1;
            end
            REQ_BYTE: if (!rx_push(r.rbyte)) o.ovf = 1'b1;
            default: ;
        endcase
        case (irq_sel)
            4'd1: o.line = 4'd4;
            4'd2: o.line = 4'd5;
            4'd4: o.line = 4'd10;
            4'd8: o.line = 4'd14;
            default: o.line = 4'd0;
        endcase
        o.irq = rx_ie && (rx_fill != 0);
        return o;
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    // send one request, predict its response
    task automatic send_req(t_req r);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            wait_cycles(gap);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {r.rbyte, r.len, r.wdata, r.ofs, r.kind};
        do @(posedge i_clk); while (!o_s_tready);
        pending_resp = {pending_resp, card_step(r)};
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_resp.size() != 0 && cycles < CYCLE_LIMIT) @(posedge i_clk);
        wait_cycles(4);
    endtask

    task automatic write_mac(logic [47:0] m);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        station_mac = m;
    endtask

    function automatic t_req mk(logic [2:0] k, logic [4:0] o, logic [7:0] w,
                                logic [15:0] l, logic [7:0] b);
        t_req r;
        r.kind = k; r.ofs = o; r.wdata = w; r.len = l; r.rbyte = b;
        return r;
    endfunction

    // random request, biased towards bank 2 traffic and packet flow
    function automatic t_req rand_req();
        int   sel;
        t_req r;
        sel = $urandom_range(0, 99);
        r = mk(3'($urandom_range(0, 4)), 5'($urandom_range(0, 16)),
               8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
               8'($urandom_range(0, 255)));
        if (sel < 4) r.kind = 3'($urandom_range(5, 7));
        else if (sel < 7) r.ofs = 5'($urandom_range(17, 31));
        else if (sel < 12) begin
            r.kind = REQ_WRITE; r.ofs = OFS_CFG1;
            r.wdata[3:2] = ($urandom_range(0, 1) != 0) ? 2'd2 : 2'($urandom_range(0, 3));
        end else if (sel < 30) r.kind = REQ_BYTE;
        else if (sel < 38) r.kind = REQ_PKT;
        else if (sel < 55) begin
            r.kind = ($urandom_range(0, 2) == 0) ? REQ_WORD : REQ_READ;
            r.ofs = ($urandom_range(0, 1) != 0) ? OFS_BUF0 : OFS_BUF1;
        end else if (sel < 65) begin
            r.kind = REQ_WRITE; r.ofs = 5'($urandom_range(OFS_BUF0, OFS_TXGO));
            if (r.ofs == OFS_TXGO && $urandom_range(0, 1) != 0) r.wdata |= 8'h81;
        end else if (sel < 72) begin
            r.kind = REQ_READ; r.ofs = OFS_ROM;
        end else if (sel < 75) begin
            r.kind = REQ_WRITE; r.ofs = OFS_RXIE;
            if ($urandom_range(0, 1) != 0) r.wdata |= 8'h81;
        end else if (sel < 78) begin
            r.kind = REQ_WRITE; r.ofs = OFS_ROM;
        end
        return r;
    endfunction

    // response check
    always @(posedge i_clk) begin
        t_resp got, want;
        cycles <= cycles + 1;
        if (i_rst_n) i_m_tready <= ($urandom_range(0, 9) < 6);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '0;
            got.rdata = o_m_tdata[15:0];
            got.irq = o_m_tdata[16];
            got.line = o_m_tdata[20:17];
            got.txv = o_m_tdata[21];
            got.txb = o_m_tdata[29:22];
            got.txl = o_m_tdata[41:30];
            got.ovf = o_m_tdata[42];
            got.txe = o_m_tlast;
            if (pending_resp.size() == 0) begin
                $error("response with nothing pending: %h", o_m_tdata);
                errors++;
            end else begin
                want = pending_resp.pop_front();
                resp_seen++;
                if (want.ovf) ovf_seen++;
                if (want.txe) tx_end_seen++;
                if (got.rdata !== want.rdata) begin
                    $error("read_data exp %h got %h", want.rdata, got.rdata); errors++;
                end
                if (got.irq !== want.irq) begin
                    $error("irq_request exp %0d got %0d", want.irq, got.irq); errors++;
                end
                if (got.line !== want.line) begin
                    $error("irq_line exp %0d got %0d", want.line, got.line); errors++;
                end
                if (got.txv !== want.txv) begin
                    $error("tx_valid exp %0d got %0d", want.txv, got.txv); errors++;
                end
                if (got.txb !== want.txb) begin
                    $error("tx_byte exp %h got %h", want.txb, got.txb); errors++;
                end
                if (got.txe !== want.txe) begin
                    $error("tx_end exp %0d got %0d", want.txe, got.txe); errors++;
                end
                if (got.txl !== want.txl) begin
                    $error("tx_length exp %0d got %0d", want.txl, got.txl); errors++;
                end
                if (got.ovf !== want.ovf) begin
                    $error("rx_overflow exp %0d got %0d", want.ovf, got.ovf); errors++;
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // directed table: request plus a typed expected read value where obvious
    t_req        dir_req [$];
    logic [16:0] dir_rd [$];   // bit 16 marks a typed expectation

    task automatic add_dir(t_req r, bit known, logic [15:0] v);
        dir_req = {dir_req, r};
        dir_rd = {dir_rd, {known, v}};
    endtask

    // stimulus
    initial begin
        t_resp exp_r;
        for (int i = 0; i < BANK_COUNT*NUM_REGS; i++) bank_regs[i] = 8'hFF;
        rx_rd = 0; rx_fill = 0; tx_cnt = 0; rom_ptr = '0;
        rx_ie = 1'b0; tx_ie = 1'b0; cfg0 = '0; cfg1 = '0; irq_sel = '0; station_mac = '0;
        wait_cycles(7);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mac(48'hFFFF_FFFF_FFFF);

        add_dir(mk(REQ_READ, 5'd0, 8'h00, 16'h0, 8'h00), 1, 16'h00FF);
        add_dir(mk(REQ_READ, OFS_STATUS, 8'h00, 16'h0, 8'h00), 1, 16'h0000);
        add_dir(mk(REQ_READ, 5'd31, 8'h00, 16'h0, 8'h00), 1, 16'h00FF);
        add_dir(mk(REQ_WRITE, 5'd31, 8'hFF, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_READ, OFS_ROM, 8'h00, 16'h0, 8'h00), 1, 16'h0000);
        add_dir(mk(REQ_WRITE, OFS_ROM, 8'h30, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_WRITE, OFS_ROM, 8'h80, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_WRITE, OFS_RXIE, 8'h81, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_PKT, 5'd0, 8'h00, 16'hFFFF, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_BYTE, 5'd0, 8'h00, 16'h0, 8'hFF), 0, 16'h0);
        add_dir(mk(REQ_WRITE, OFS_CFG1, 8'h08, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_WORD, OFS_BUF0, 8'h00, 16'h0, 8'h00), 1, 16'h0020);
        add_dir(mk(REQ_WORD, OFS_BUF0, 8'h00, 16'h0, 8'h00), 1, 16'hFFFF);
        add_dir(mk(REQ_READ, OFS_BUF1, 8'h00, 16'h0, 8'h00), 1, 16'h00FF);
        add_dir(mk(REQ_WORD, OFS_BUF0, 8'h00, 16'h0, 8'h00), 1, 16'h0000);
        add_dir(mk(REQ_WRITE, OFS_BUF0, 8'hA5, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_WRITE, OFS_BUF1, 8'h00, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_WRITE, OFS_TXGO, 8'h81, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_WORD, OFS_STAT5, 8'h00, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_WORD, 5'd16, 8'h00, 16'h0, 8'h00), 1, 16'hFF00 | 16'h0080);
        add_dir(mk(REQ_WRITE, OFS_CFG1, 8'h0C, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_WRITE, OFS_CFG0, 8'h5A, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_WRITE, OFS_TXIE, 8'h82, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(3'd7, 5'd0, 8'h00, 16'h0, 8'h00), 0, 16'h0);
        add_dir(mk(REQ_WRITE, OFS_CFG1, 8'h00, 16'h0, 8'h00), 0, 16'h0);
        for (int i = 0; i < dir_req.size(); i++) begin
            send_req(dir_req[i]);
            exp_r = pending_resp[$];
            if (dir_rd[i][16] && exp_r.rdata !== dir_rd[i][15:0]) begin
                $error("directed read_data exp %h model %h", dir_rd[i][15:0], exp_r.rdata);
                errors++;
            end
        end

        // random phases over several station addresses
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_mac(48'h0);
                1: write_mac(48'({$urandom(), $urandom()}));
                2: write_mac(48'hA5A5_0F0F_F0F0);
                default: write_mac(48'hFFFF_FFFF_FFFF);
            endcase
            for (int n = 0; n < 65; n++) send_req(rand_req());
            if (ph == 1) drain();
        end

        // fill the fifo past full, then take some of it back through bank 2
        send_req(mk(REQ_WRITE, OFS_CFG1, 8'h08, 16'h0, 8'h00));
        for (int n = 0; n < 515; n++) send_req(mk(REQ_PKT, 5'd0, 8'h00,
                                                 16'($urandom_range(0, 65535)), 8'h00));
        for (int n = 0; n < 4; n++) send_req(mk(REQ_BYTE, 5'd0, 8'h00, 16'h0,
                                               8'($urandom_range(0, 255))));
        for (int n = 0; n < 10; n++) send_req(mk(REQ_WORD, OFS_BUF0, 8'h00, 16'h0, 8'h00));
        for (int n = 0; n < 20; n++) send_req(rand_req());

        drain();
        $display("checked %0d responses: register, rom, fifo and transmit paths", resp_seen);
        $display("%0d drop events, %0d frame ends seen", ovf_seen, tx_end_seen);
        if (errors == 0 && pending_resp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: lan_card_register_interface.f
rtl/lcri_pkg.sv
rtl/lcri_bank.sv
rtl/lcri_rxfifo.sv
rtl/lan_card_register_interface.sv
test/tb_lan_card_register_interface.sv
